@@ rtl/htfc_pkg.sv @@
package htfc_pkg;

    localparam int RAW_W      = 16;
    localparam int CHK_W      = 8;
    localparam int SCALE_W    = 8;
    localparam int PROD_W     = RAW_W + SCALE_W;
    localparam int HUM_W      = 7;
    localparam int TMP_W      = 9;
    localparam int MAG_W      = 8;
    localparam int FRAC_W     = 16;

    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 24;

    localparam logic [CHK_W-1:0]   CRC_INIT   = 8'hFF;
    localparam logic [CHK_W-1:0]   CRC_POLY   = 8'h31;
    localparam logic [SCALE_W-1:0] HUM_SCALE  = 8'd100;
    localparam logic [SCALE_W-1:0] TMP_SCALE  = 8'd175;
    localparam logic [PROD_W-1:0]  TMP_OFFSET = PROD_W'(45) << FRAC_W;

    typedef struct packed {
        logic              ok;
        logic [PROD_W-1:0] prod;
    } t_lane_res;

    function automatic logic [CHK_W-1:0] crc8_byte(
        input logic [CHK_W-1:0] crc_in,
        input logic [7:0]       data
    );
        logic [CHK_W-1:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (crc[CHK_W-1]) begin
                crc = {crc[CHK_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[CHK_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

@@ rtl/htfc_lane.sv @@
module htfc_lane
    import htfc_pkg::*;
#(
    parameter logic [SCALE_W-1:0] P_SCALE = HUM_SCALE
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RAW_W-1:0] i_raw,
    input  logic [CHK_W-1:0] i_check,
    output t_lane_res        o_res
);

    logic [CHK_W-1:0] crc_hi;
    logic [CHK_W-1:0] crc_lo;
    t_lane_res        r_res;
    t_lane_res        n_res;

    // high byte first
    always_comb begin
        crc_hi     = crc8_byte(CRC_INIT, i_raw[RAW_W-1:8]);
        crc_lo     = crc8_byte(crc_hi, i_raw[7:0]);
        n_res.ok   = (crc_lo == i_check);
        n_res.prod = PROD_W'(i_raw) * PROD_W'(P_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ rtl/humidity_temp_frame_check_convert.sv @@
// Checks and converts one six-byte humidity/temperature frame per beat. Each
// raw word is verified with CRC-8 (poly 0x31, init 0xFF, high byte first);
// humidity becomes whole percent, temperature whole degrees C (signed,
// truncated toward zero). A failed check gives value 0 with its ok flag low.
// Two lanes (CRC plus constant multiply) run side by side, then a merge stage
// scales, offsets and packs into the output register; a new frame is taken
// every cycle while the output is drained.
module humidity_temp_frame_check_convert
    import htfc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // hum_raw[15:0], hum_check[23:16], tmp_raw[39:24], tmp_check[47:40]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // hum_percent[6:0], hum_ok[7], tmp_celsius[16:8], tmp_ok[17], zero[23:18]
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    logic                r_v1;
    logic                r_v2;
    logic                en1;
    logic                en2;
    t_lane_res           hum_res;
    t_lane_res           tmp_res;
    logic [HUM_W-1:0]    hum_pct;
    logic [TMP_W-1:0]    tmp_deg;
    logic [PROD_W-1:0]   tmp_diff;
    logic [MAG_W-1:0]    tmp_mag;
    logic [M_DATA_W-1:0] r_out;
    logic [M_DATA_W-1:0] n_out;

    assign en2           = !r_v2 || m_axis_tready;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;

    htfc_lane #(.P_SCALE(HUM_SCALE)) u_hum_lane (
        .i_clk   (i_clk),
        .i_en    (en1),
        .i_raw   (s_axis_tdata[15:0]),
        .i_check (s_axis_tdata[23:16]),
        .o_res   (hum_res)
    );

    htfc_lane #(.P_SCALE(TMP_SCALE)) u_tmp_lane (
        .i_clk   (i_clk),
        .i_en    (en1),
        .i_raw   (s_axis_tdata[39:24]),
        .i_check (s_axis_tdata[47:40]),
        .o_res   (tmp_res)
    );

    // merge: scale down, apply offset, zero on failed check
    always_comb begin
        hum_pct  = hum_res.ok ? hum_res.prod[FRAC_W +: HUM_W] : '0;
        if (tmp_res.prod >= TMP_OFFSET) begin
            tmp_diff = tmp_res.prod - TMP_OFFSET;
            tmp_mag  = tmp_diff[FRAC_W +: MAG_W];
            tmp_deg  = {1'b0, tmp_mag};
        end else begin
            tmp_diff = TMP_OFFSET - tmp_res.prod;
            tmp_mag  = tmp_diff[FRAC_W +: MAG_W];
            tmp_deg  = -{1'b0, tmp_mag};
        end
        if (!tmp_res.ok) begin
            tmp_deg = '0;
        end
        n_out = {6'd0, tmp_res.ok, tmp_deg, hum_res.ok, hum_pct};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = r_out;

endmodule

@@ rtl/htfc_checker.sv @@
module htfc_checker
    import htfc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_hum_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[6:0] == 7'd0)
        else $error("humidity nonzero on failed check");

    a_tmp_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[17] |-> m_axis_tdata[16:8] == 9'd0)
        else $error("temperature nonzero on failed check");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd99)
        else $error("humidity out of range");

    a_tmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[16:8]) >= -9'sd45
                       && $signed(m_axis_tdata[16:8]) <= 9'sd129)
        else $error("temperature out of range");

endmodule

bind humidity_temp_frame_check_convert htfc_checker u_htfc_checker (.*);
